// ===== hw/rtl/drt_pkg.sv =====
// Shared types, constants and helpers for the distance-vector route table.
package drt_pkg;

  localparam int MAX_ROUTERS = 8;
  localparam int IDX_W       = $clog2(MAX_ROUTERS);
  localparam int CNT_W       = IDX_W + 1;
  localparam int COST_BITS   = 16;
  localparam int TIMER_W     = 16;
  localparam int MISS_W      = 2;
  localparam int ADDR_W      = 2 * IDX_W;
  localparam int CFG_IDX_W   = 2;

  localparam logic [COST_BITS-1:0] COST_INF   = '1;
  localparam logic [MISS_W-1:0]    MISS_LIMIT = 2'd3;

  // Request modes.
  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_VECTOR = 2'd1,
    MODE_DOWN   = 2'd2,
    MODE_TICK   = 2'd3
  } mode_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OWN_INDEX      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROUTER_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_TICKS = 2'd2;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_LD_RD,
    S_LD_WR,
    S_DISPATCH,
    S_V_WR,
    S_RC_RD,
    S_RC_WR,
    S_RX_RD,
    S_RX_EV,
    S_CLR,
    S_TICK,
    S_EMIT
  } state_t;

  // Datapath commands.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_LD_RD,
    OP_LD_WR,
    OP_LOAD_OWN,
    OP_V_RD,
    OP_V_WR,
    OP_RC_RD,
    OP_RC_WR,
    OP_RX_RD,
    OP_RX_EV,
    OP_CLR_CHG,
    OP_DOWN,
    OP_TICK_STEP,
    OP_EM_NEXT
  } op_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic  ignore;
    mode_t mode;
    logic  last;
    logic  chg_new;
    logic  ld_last;
    logic  ci_last;
    logic  rx_last;
    logic  t_last;
    logic  t_emit;
    logic  t_down;
  } status_t;

  // Cost sum that saturates at infinity.
  function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
                                                   input logic [COST_BITS-1:0] b);
    logic [COST_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == COST_INF || b == COST_INF || s >= {1'b0, COST_INF}) begin
      sat_add = COST_INF;
    end else begin
      sat_add = s[COST_BITS-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/distance_vector_route_table.sv =====
// Sequence: after the accept state a request passes a check state and a load of the whole own
// row into the cache; then a load or vector entry is written, a down runs a relaxation pass,
// and a changed final vector entry re-costs the own row, runs a relaxation pass and a clear.
// Requests are taken one at a time; a tick steps through the N routers, adding a relaxation
// pass per expired neighbor and N handshakes per own broadcast.
// Reset: synchronous; cost table reads as unreachable, timers disabled, misses full.
module distance_vector_route_table import drt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIMER_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           mode,
  input  logic [IDX_W-1:0]     router_index,
  input  logic [IDX_W-1:0]     dest_index,
  input  logic [COST_BITS-1:0] entry_cost,
  input  logic [IDX_W-1:0]     entry_next_hop,
  input  logic                 entry_is_neighbor,
  input  logic                 last_entry,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     row_dest,
  output logic [COST_BITS-1:0] row_cost,
  output logic                 row_last
);

  op_t     op;
  status_t st;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  drt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .op        (op)
  );

  drt_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .op                (op),
    .mode              (mode),
    .router_index      (router_index),
    .dest_index        (dest_index),
    .entry_cost        (entry_cost),
    .entry_next_hop    (entry_next_hop),
    .entry_is_neighbor (entry_is_neighbor),
    .last_entry        (last_entry),
    .st                (st),
    .row_dest          (row_dest),
    .row_cost          (row_cost),
    .row_last          (row_last)
  );

  // No new request is taken while a broadcast is under way.
  a_no_accept_in_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("request accepted during broadcast");

  // An accepted request is followed by at least one busy cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accept");

  // The broadcast ends on the entry marked last.
  a_row_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && row_last) |=> !out_valid)
    else $error("broadcast continues past last entry");

endmodule

// ===== hw/rtl/drt_ctrl.sv =====
// Sequencing state machine for the distance-vector route table.
module drt_ctrl import drt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t st,
  output op_t     op
);

  state_t state, state_next;
  state_t ret, ret_next;

  // State and return-state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    ret_next   = ret;
    op         = OP_NONE;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = OP_LATCH;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = st.ignore ? S_IDLE : S_LD_RD;
      end
      S_LD_RD: begin
        op         = OP_LD_RD;
        state_next = S_LD_WR;
      end
      S_LD_WR: begin
        op         = OP_LD_WR;
        state_next = st.ld_last ? S_DISPATCH : S_LD_RD;
      end
      S_DISPATCH: begin
        unique case (st.mode)
          MODE_LOAD: begin
            op         = OP_LOAD_OWN;
            state_next = S_IDLE;
          end
          MODE_VECTOR: begin
            op         = OP_V_RD;
            state_next = S_V_WR;
          end
          MODE_DOWN: begin
            op         = OP_DOWN;
            ret_next   = S_IDLE;
            state_next = S_RX_RD;
          end
          MODE_TICK: begin
            state_next = S_TICK;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_V_WR: begin
        op         = OP_V_WR;
        state_next = (st.last && st.chg_new) ? S_RC_RD : S_IDLE;
      end
      S_RC_RD: begin
        op         = OP_RC_RD;
        state_next = S_RC_WR;
      end
      S_RC_WR: begin
        op = OP_RC_WR;
        if (st.ci_last) begin
          ret_next   = S_CLR;
          state_next = S_RX_RD;
        end else begin
          state_next = S_RC_RD;
        end
      end
      S_RX_RD: begin
        op         = OP_RX_RD;
        state_next = S_RX_EV;
      end
      S_RX_EV: begin
        op         = OP_RX_EV;
        state_next = st.rx_last ? ret : S_RX_RD;
      end
      S_CLR: begin
        op         = OP_CLR_CHG;
        state_next = S_IDLE;
      end
      S_TICK: begin
        op       = OP_TICK_STEP;
        ret_next = st.t_last ? S_IDLE : S_TICK;
        if (st.t_emit) begin
          state_next = S_EMIT;
        end else if (st.t_down) begin
          state_next = S_RX_RD;
        end else begin
          state_next = st.t_last ? S_IDLE : S_TICK;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          op = OP_EM_NEXT;
          if (st.ci_last) begin
            state_next = ret;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/drt_datapath.sv =====
// Cost table memory, own-row cache, timers and arithmetic of the route table.
module drt_datapath import drt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIMER_W-1:0]   cfg_data,
  input  op_t                  op,
  input  logic [1:0]           mode,
  input  logic [IDX_W-1:0]     router_index,
  input  logic [IDX_W-1:0]     dest_index,
  input  logic [COST_BITS-1:0] entry_cost,
  input  logic [IDX_W-1:0]     entry_next_hop,
  input  logic                 entry_is_neighbor,
  input  logic                 last_entry,
  output status_t              st,
  output logic [IDX_W-1:0]     row_dest,
  output logic [COST_BITS-1:0] row_cost,
  output logic                 row_last
);

  // Configuration registers.
  logic [IDX_W-1:0]   own_index;
  logic [CNT_W-1:0]   router_count;
  logic [TIMER_W-1:0] interval_ticks;

  // Latched request.
  mode_t              req_mode;
  logic [IDX_W-1:0]   req_r, req_d, req_nh;
  logic [COST_BITS-1:0] req_cost;
  logic               req_nb, req_last;

  // Counters and flags.
  logic [IDX_W-1:0] ci, ti, ri, rj;
  logic             changed;

  // Per-router state.
  logic [COST_BITS-1:0] cache [MAX_ROUTERS];
  logic [IDX_W-1:0]     nh [MAX_ROUTERS];
  logic                 nbr [MAX_ROUTERS];
  logic [TIMER_W-1:0]   cd [MAX_ROUTERS];
  logic [MISS_W-1:0]    miss [MAX_ROUTERS];

  // Cost table memory with valid bits; an unwritten entry reads as infinity.
  logic [COST_BITS-1:0]          mem [MAX_ROUTERS*MAX_ROUTERS];
  logic [MAX_ROUTERS*MAX_ROUTERS-1:0] mem_valid;
  logic [COST_BITS-1:0]          rd_q;
  logic                          rd_vq;
  logic [COST_BITS-1:0]          rd_cost;

  // Stage registers for one relaxation or re-cost step.
  logic [COST_BITS-1:0] aux_q, ownj_q;
  logic [IDX_W-1:0]     nhj_q;

  logic [CNT_W-1:0]     n, n_last;
  logic [TIMER_W-1:0]   reload;
  logic                 ci_last, ri_last, rj_last;
  logic [IDX_W-1:0]     caddr, nhaddr;
  logic [COST_BITS-1:0] crd;
  logic [IDX_W-1:0]     nhrd;
  logic [ADDR_W-1:0]    raddr, waddr;
  logic                 wr_en;
  logic [COST_BITS-1:0] wdata;
  logic [TIMER_W-1:0]   t_cd, t_dec;
  logic                 t_fire, t_own;
  logic [MISS_W-1:0]    t_miss;
  logic [COST_BITS-1:0] rx_sum, rc_val;
  logic                 rx_upd, rc_upd, chg_new, ignore;

  // Active router count and timer reload.
  assign n       = (router_count > CNT_W'(MAX_ROUTERS)) ? CNT_W'(MAX_ROUTERS) : router_count;
  assign n_last  = n - 1'b1;
  assign reload  = (interval_ticks == '0) ? TIMER_W'(1) : interval_ticks;
  assign ci_last = ({1'b0, ci} == n_last);
  assign ri_last = ({1'b0, ri} == n_last);
  assign rj_last = ({1'b0, rj} == n_last);
  assign rd_cost = rd_vq ? rd_q : COST_INF;

  // Request filter for out-of-range indexes and for vectors or downs naming the own router.
  always_comb begin
    ignore = 1'b0;
    if (n == '0 || {1'b0, own_index} >= n) begin
      ignore = 1'b1;
    end else begin
      case (req_mode)
        MODE_LOAD:   ignore = ({1'b0, req_d} >= n);
        MODE_VECTOR: ignore = ({1'b0, req_r} >= n) || ({1'b0, req_d} >= n) ||
                              (req_r == own_index);
        MODE_DOWN:   ignore = ({1'b0, req_r} >= n) || (req_r == own_index);
        default:     ignore = 1'b0;
      endcase
    end
  end

  // Cache and next-hop read selection.
  always_comb begin
    case (op)
      OP_RX_RD: caddr = rj;
      OP_RX_EV: caddr = ri;
      OP_RC_RD: caddr = req_r;
      default:  caddr = ci;
    endcase
    nhaddr = (op == OP_RX_RD) ? rj : ci;
  end
  assign crd  = cache[caddr];
  assign nhrd = nh[nhaddr];

  // Timer step for the router under the tick sweep.
  assign t_cd   = cd[ti];
  assign t_dec  = t_cd - 1'b1;
  assign t_fire = (t_cd != '0) && (t_dec == '0);
  assign t_own  = (ti == own_index);
  assign t_miss = (miss[ti] != '0) ? miss[ti] - 1'b1 : '0;

  // Relaxation and re-cost arithmetic.
  assign rx_sum  = sat_add(ownj_q, rd_cost);
  assign rx_upd  = (crd > rd_cost) && (rx_sum < crd);
  assign rc_upd  = (ci != own_index) && (nhrd == req_r);
  assign rc_val  = sat_add(rd_cost, aux_q);
  assign chg_new = changed || (rd_cost != req_cost);

  // Memory address and write selection.
  always_comb begin
    raddr = {own_index, ci};
    waddr = {own_index, ci};
    wr_en = 1'b0;
    wdata = COST_INF;
    case (op)
      OP_V_RD:  raddr = {req_r, req_d};
      OP_RC_RD: raddr = {req_r, ci};
      OP_RX_RD: raddr = {rj, ri};
      OP_LOAD_OWN: begin
        wr_en = 1'b1;
        waddr = {own_index, req_d};
        wdata = req_cost;
      end
      OP_V_WR: begin
        wr_en = 1'b1;
        waddr = {req_r, req_d};
        wdata = req_cost;
      end
      OP_RC_WR: begin
        wr_en = rc_upd;
        wdata = rc_val;
      end
      OP_RX_EV: begin
        wr_en = rx_upd;
        waddr = {own_index, ri};
        wdata = rx_sum;
      end
      OP_DOWN: begin
        wr_en = 1'b1;
        waddr = {own_index, req_r};
      end
      OP_TICK_STEP: begin
        wr_en = t_fire && !t_own && (t_miss == '0);
        waddr = {own_index, ti};
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Cost table memory.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // Valid bits of the cost table.
  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= '0;
      rd_vq     <= 1'b0;
    end else begin
      if (wr_en) begin
        mem_valid[waddr] <= 1'b1;
      end
      rd_vq <= mem_valid[raddr];
    end
  end

  // Request payload, own-row cache and step registers.
  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        req_mode <= mode_t'(mode);
        req_r    <= router_index;
        req_d    <= dest_index;
        req_cost <= entry_cost;
        req_nh   <= entry_next_hop;
        req_nb   <= entry_is_neighbor;
        req_last <= last_entry;
      end
      OP_LD_WR:    cache[ci] <= rd_cost;
      OP_LOAD_OWN: cache[req_d] <= req_cost;
      OP_RC_RD:    aux_q <= crd;
      OP_RC_WR: begin
        if (rc_upd) begin
          cache[ci] <= rc_val;
        end
      end
      OP_RX_RD: begin
        ownj_q <= crd;
        nhj_q  <= nhrd;
      end
      OP_RX_EV: begin
        if (rx_upd) begin
          cache[ri] <= rx_sum;
        end
      end
      OP_DOWN: cache[req_r] <= COST_INF;
      OP_TICK_STEP: begin
        if (t_fire && !t_own && t_miss == '0) begin
          cache[ti] <= COST_INF;
        end
      end
      default: ;
    endcase
  end

  // Configuration, counters, next hops, neighbor flags and timers.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_index      <= '0;
      router_count   <= CNT_W'(MAX_ROUTERS);
      interval_ticks <= TIMER_W'(30);
      ci      <= '0;
      ti      <= '0;
      ri      <= '0;
      rj      <= '0;
      changed <= 1'b0;
      for (int k = 0; k < MAX_ROUTERS; k++) begin
        nh[k]   <= '0;
        nbr[k]  <= 1'b0;
        cd[k]   <= '0;
        miss[k] <= MISS_LIMIT;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OWN_INDEX:      own_index <= cfg_data[IDX_W-1:0];
          REG_ROUTER_COUNT:   router_count <= cfg_data[CNT_W-1:0];
          REG_INTERVAL_TICKS: interval_ticks <= cfg_data;
          default: ;
        endcase
      end
      case (op)
        OP_LATCH: begin
          ci <= '0;
          ti <= '0;
          ri <= '0;
          rj <= '0;
        end
        OP_LD_WR: ci <= ci + 1'b1;
        OP_LOAD_OWN: begin
          nh[req_d]     <= req_nh;
          cd[own_index] <= reload;
          if (req_d == own_index) begin
            nbr[req_d] <= 1'b0;
          end else begin
            nbr[req_d]  <= req_nb;
            cd[req_d]   <= req_nb ? reload : '0;
            miss[req_d] <= MISS_LIMIT;
          end
        end
        OP_V_WR: begin
          changed <= chg_new;
          if (req_last) begin
            cd[req_r]   <= reload;
            miss[req_r] <= MISS_LIMIT;
          end
        end
        OP_RC_WR: ci <= ci_last ? '0 : ci + 1'b1;
        OP_RX_EV: begin
          if (rx_upd) begin
            nh[ri] <= nhj_q;
          end
          if (rj_last) begin
            rj <= '0;
            ri <= ri_last ? '0 : ri + 1'b1;
          end else begin
            rj <= rj + 1'b1;
          end
        end
        OP_CLR_CHG: changed <= 1'b0;
        OP_DOWN: begin
          nbr[req_r]  <= 1'b0;
          cd[req_r]   <= '0;
          miss[req_r] <= MISS_LIMIT;
        end
        OP_TICK_STEP: begin
          ti <= ti + 1'b1;
          if (t_cd != '0) begin
            if (!t_fire) begin
              cd[ti] <= t_dec;
            end else if (t_own) begin
              cd[ti] <= reload;
            end else if (t_miss == '0) begin
              nbr[ti]  <= 1'b0;
              cd[ti]   <= '0;
              miss[ti] <= MISS_LIMIT;
            end else begin
              cd[ti]   <= reload;
              miss[ti] <= t_miss;
            end
          end
        end
        OP_EM_NEXT: ci <= ci_last ? '0 : ci + 1'b1;
        default: ;
      endcase
    end
  end

  // Status to the controller.
  assign st.ignore  = ignore;
  assign st.mode    = req_mode;
  assign st.last    = req_last;
  assign st.chg_new = chg_new;
  assign st.ld_last = (ci == IDX_W'(MAX_ROUTERS - 1));
  assign st.ci_last = ci_last;
  assign st.rx_last = ri_last && rj_last;
  assign st.t_last  = ({1'b0, ti} == n_last);
  assign st.t_emit  = t_fire && t_own;
  assign st.t_down  = t_fire && !t_own && (t_miss == '0);

  // Broadcast row entry.
  assign row_dest = ci;
  assign row_cost = crd;
  assign row_last = ci_last;

endmodule

// ===== tb/tb_distance_vector_route_table.sv =====
// Self-checking testbench for the distance-vector route table block.
`timescale 1ns / 1ps

module tb_distance_vector_route_table;
  import drt_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]     dest;
    logic [COST_BITS-1:0] cost;
    logic                 last;
  } row_entry_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIMER_W-1:0]   cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           mode = '0;
  logic [IDX_W-1:0]     router_index = '0;
  logic [IDX_W-1:0]     dest_index = '0;
  logic [COST_BITS-1:0] entry_cost = '0;
  logic [IDX_W-1:0]     entry_next_hop = '0;
  logic                 entry_is_neighbor = 1'b0;
  logic                 last_entry = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [IDX_W-1:0]     row_dest;
  logic [COST_BITS-1:0] row_cost;
  logic                 row_last;

  // Shadow copy of the routing state.
  logic [2:0]           sh_own;
  logic [3:0]           sh_count;
  logic [15:0]          sh_interval;
  logic [COST_BITS-1:0] sh_cost [0:7][0:7];
  logic [IDX_W-1:0]     sh_hop [0:7];
  logic                 sh_nbr [0:7];
  logic [15:0]          sh_timer [0:7];
  logic [1:0]           sh_miss [0:7];
  logic                 sh_changed;

  row_entry_t expected_rows[$];
  int  error_count = 0;
  int  cycle_count = 0;
  int  hold_off = 0;
  int  rx_wait = 0;
  bit  random_stall = 1'b1;

  distance_vector_route_table i_dut (.*);

  always #5 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("** distance_vector_route_table: FAILED **");
      $finish;
    end
  end

  function automatic logic [15:0] reload_ticks();
    return (sh_interval == 0) ? 16'd1 : sh_interval;
  endfunction

  function automatic int used_routers();
    return (sh_count > 8) ? 8 : int'(sh_count);
  endfunction

  function automatic logic [COST_BITS-1:0] add_cost(logic [COST_BITS-1:0] a,
                                                    logic [COST_BITS-1:0] b);
    logic [COST_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == COST_INF || b == COST_INF || s >= {1'b0, COST_INF}) return COST_INF;
    return s[COST_BITS-1:0];
  endfunction

  task automatic relax_own_row(int n);
    logic [COST_BITS-1:0] sum;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (sh_cost[sh_own][i] > sh_cost[j][i]) begin
          sum = add_cost(sh_cost[sh_own][j], sh_cost[j][i]);
          if (sum < sh_cost[sh_own][i]) begin
            sh_cost[sh_own][i] = sum;
            sh_hop[i] = sh_hop[j];
          end
        end
  endtask

  task automatic drop_neighbor(int r, int n);
    sh_cost[sh_own][r] = COST_INF;
    sh_nbr[r] = 1'b0;
    sh_timer[r] = '0;
    sh_miss[r] = MISS_LIMIT;
    relax_own_row(n);
  endtask

  task automatic reset_shadow();
    sh_own = 0; sh_count = 8; sh_interval = 30; sh_changed = 0;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) sh_cost[i][j] = COST_INF;
      sh_hop[i] = 0; sh_nbr[i] = 0; sh_timer[i] = 0; sh_miss[i] = MISS_LIMIT;
    end
  endtask

  // Update the shadow state for one accepted request and queue any broadcast rows.
  task automatic predict_request(logic [1:0] m, int r, int d, logic [15:0] c,
                                 logic [2:0] nh, logic nb, logic lst);
    int n;
    row_entry_t e;
    n = used_routers();
    if (n == 0 || sh_own >= n) return;
    case (mode_t'(m))
      MODE_LOAD: begin
        if (d >= n) return;
        sh_cost[sh_own][d] = c;
        sh_hop[d] = nh;
        sh_timer[sh_own] = reload_ticks();
        if (d == sh_own) sh_nbr[d] = 1'b0;
        else begin
          sh_nbr[d] = nb;
          sh_timer[d] = nb ? reload_ticks() : 16'd0;
          sh_miss[d] = MISS_LIMIT;
        end
      end
      MODE_VECTOR: begin
        if (r >= n || d >= n || r == sh_own) return;
        if (sh_cost[r][d] != c) sh_changed = 1'b1;
        sh_cost[r][d] = c;
        if (lst) begin
          sh_timer[r] = reload_ticks();
          sh_miss[r] = MISS_LIMIT;
          if (sh_changed) begin
            for (int i = 0; i < n; i++)
              if (i != sh_own && sh_hop[i] == r)
                sh_cost[sh_own][i] = add_cost(sh_cost[r][i], sh_cost[sh_own][r]);
            relax_own_row(n);
          end
          sh_changed = 1'b0;
        end
      end
      MODE_DOWN: begin
        if (r >= n || r == sh_own) return;
        drop_neighbor(r, n);
      end
      default: begin
        for (int i = 0; i < n; i++) begin
          if (sh_timer[i] == 0) continue;
          sh_timer[i]--;
          if (sh_timer[i] != 0) continue;
          sh_timer[i] = reload_ticks();
          if (i == sh_own) begin
            for (int k = 0; k < n; k++) begin
              e.dest = k[IDX_W-1:0];
              e.cost = sh_cost[sh_own][k];
              e.last = (k == n - 1);
              expected_rows.push_back(e);
            end
          end else begin
            if (sh_miss[i] > 0) sh_miss[i]--;
            if (sh_miss[i] == 0) drop_neighbor(i, n);
          end
        end
      end
    endcase
  endtask

  // Send one request; the prediction is made when it is accepted. Valid stays up after
  // the accept until the next request replaces it or an idle gap or drain lowers it.
  task automatic send_request(int m, int r, int d, int c,
                              int nh = 0, int nb = 0, int lst = 0);
    int gap;
    gap = random_stall ? int'($urandom_range(0, 8)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m[1:0];
    router_index <= r[IDX_W-1:0];
    dest_index <= d[IDX_W-1:0];
    entry_cost <= c[COST_BITS-1:0];
    entry_next_hop <= nh[IDX_W-1:0];
    entry_is_neighbor <= nb[0];
    last_entry <= lst[0];
    do @(posedge clk); while (!in_ready);
    predict_request(m[1:0], r, d, c[15:0], nh[2:0], nb[0], lst[0]);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_OWN_INDEX) sh_own = value[2:0];
    else if (idx == REG_ROUTER_COUNT) sh_count = value[3:0];
    else sh_interval = value;
  endtask

  // Wait for all expected rows, then for the block to finish the request in progress.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic set_config(int own, int count, int interval);
    drain();
    write_register(REG_OWN_INDEX, own[15:0]);
    write_register(REG_ROUTER_COUNT, count[15:0]);
    write_register(REG_INTERVAL_TICKS, interval[15:0]);
    cfg_valid <= 1'b0;
  endtask

  // Receiver stall: a drawn wait after each result, or one long hold-off.
  always @(posedge clk) begin
    int w;
    if (rst) out_ready <= 1'b0;
    else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (out_valid && out_ready) begin
      w = random_stall ? int'($urandom_range(0, 8)) : 0;
      rx_wait <= w;
      out_ready <= (w == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else out_ready <= 1'b1;
  end

  // Compare each broadcast row entry with the oldest expectation.
  always @(posedge clk) begin
    row_entry_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        $error("unexpected row entry dest=%0d cost=%0d", row_dest, row_cost);
        error_count++;
      end else begin
        e = expected_rows.pop_front();
        if (row_dest !== e.dest) begin
          $error("row_dest expected %0d actual %0d", e.dest, row_dest); error_count++;
        end
        if (row_cost !== e.cost) begin
          $error("row_cost expected %0d actual %0d", e.cost, row_cost); error_count++;
        end
        if (row_last !== e.last) begin
          $error("row_last expected %0d actual %0d", e.last, row_last); error_count++;
        end
      end
    end
  end

  task automatic test_loads_and_broadcast();
    set_config(0, 4, 1);
    send_request(MODE_LOAD, 0, 0, 0, 0, 1);
    send_request(MODE_LOAD, 0, 1, 5, 1, 1);
    send_request(MODE_LOAD, 0, 2, 16'hFFFF, 2, 0);
    send_request(MODE_LOAD, 0, 3, 16'hFFFE, 7, 1);
    send_request(MODE_LOAD, 0, 7, 9, 3, 1);
    send_request(MODE_TICK, 7, 7, 16'h1234, 5, 1, 1);
  endtask

  task automatic test_vectors_and_down();
    set_config(2, 5, 3);
    send_request(MODE_LOAD, 0, 2, 0, 2, 1);
    send_request(MODE_LOAD, 0, 1, 4, 1, 1);
    send_request(MODE_LOAD, 0, 4, 16'hFFF0, 4, 1);
    send_request(MODE_VECTOR, 1, 0, 3, 0, 0, 0);
    send_request(MODE_VECTOR, 1, 3, 16'hFFFF, 0, 0, 0);
    send_request(MODE_VECTOR, 1, 4, 16'hFFF8, 0, 0, 1);
    send_request(MODE_VECTOR, 2, 0, 1, 0, 0, 1);
    send_request(MODE_VECTOR, 1, 4, 16'hFFF8, 0, 0, 1);
    send_request(MODE_VECTOR, 6, 0, 1, 0, 0, 1);
    send_request(MODE_DOWN, 4, 0, 0);
    send_request(MODE_DOWN, 2, 0, 0);
    for (int t = 0; t < 12; t++) send_request(MODE_TICK, 0, 0, 0);
  endtask

  task automatic test_ignored_configs();
    set_config(5, 4, 0);
    send_request(MODE_LOAD, 0, 1, 1, 1, 1);
    send_request(MODE_TICK, 0, 0, 0);
    set_config(0, 0, 1);
    send_request(MODE_TICK, 0, 0, 0);
    set_config(7, 15, 65535);
    send_request(MODE_LOAD, 0, 0, 0, 7, 0);
  endtask

  // Random traffic: mostly loads and complete vectors with frequent ticks.
  task automatic test_random_traffic(int items);
    int sent, r, len;
    sent = 0;
    while (sent < items) begin
      if (sent % 60 == 0)
        set_config($urandom_range(0, 7), $urandom_range(1, 8), $urandom_range(1, 4));
      case ($urandom_range(0, 9))
        0, 1: begin
          send_request(MODE_LOAD, $urandom_range(0, 7), $urandom_range(0, 7),
                       ($urandom_range(0, 7) == 0) ? 16'hFFFF : $urandom_range(0, 65535) >>
                       $urandom_range(0, 15), $urandom_range(0, 7), $urandom_range(0, 1));
          sent++;
        end
        2, 3, 4: begin
          r = $urandom_range(0, 7);
          len = $urandom_range(1, 8);
          for (int d = 0; d < len; d++) begin
            send_request(MODE_VECTOR, r, d, ($urandom_range(0, 5) == 0) ? 16'hFFFF :
                         $urandom_range(0, 65535) >> $urandom_range(0, 15), 0, 0, d == len - 1);
            sent++;
          end
        end
        5: begin
          send_request(MODE_DOWN, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
          sent++;
        end
        default: begin
          send_request(mode_t'($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : 3),
                       $urandom_range(0, 7), $urandom_range(0, 7), $urandom,
                       $urandom_range(0, 7), $urandom_range(0, 1), $urandom_range(0, 1));
          sent++;
        end
      endcase
    end
  endtask

  // Long receiver stall while ticks keep arriving, then a drain and ticks with no random stalls.
  task automatic test_backpressure();
    set_config(1, 8, 1);
    send_request(MODE_LOAD, 0, 3, 7, 3, 1);
    hold_off = 300;
    for (int t = 0; t < 6; t++) send_request(MODE_TICK, 0, 0, 0);
    drain();
    random_stall = 1'b0;
    for (int t = 0; t < 4; t++) send_request(MODE_TICK, 0, 0, 0);
    random_stall = 1'b1;
  endtask

  initial begin
    reset_shadow();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_loads_and_broadcast();
    test_vectors_and_down();
    test_ignored_configs();
    test_backpressure();
    test_random_traffic(186);
    drain();
    if (error_count == 0 && expected_rows.size() == 0)
      $display("** distance_vector_route_table: PASSED **");
    else
      $display("** distance_vector_route_table: FAILED **");
    $finish;
  end

endmodule
